// ===== src/aurf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package aurf_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 2048;
    localparam int FIFO_DEPTH_DEF      = 4;

    // register map, word index
    localparam logic [1:0] REG_SELF_IP     = 2'd0;
    localparam logic [1:0] REG_HOST_IP     = 2'd1;
    localparam logic [1:0] REG_LISTEN_PORT = 2'd2;
    localparam logic [1:0] REG_MAX_PAYLOAD = 2'd3;

    localparam logic [31:0] SELF_IP_RST     = 32'd3232261122;
    localparam logic [31:0] HOST_IP_RST     = 32'd3232261121;
    localparam logic [15:0] LISTEN_PORT_RST = 16'd43210;
    localparam logic [10:0] MAX_PAYLOAD_RST = 11'd1023;

    localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
    localparam logic [15:0] ARP_OP_REQ    = 16'd1;
    localparam logic [15:0] ARP_OP_RPL    = 16'd2;
    localparam logic [3:0]  IHL_MASK      = 4'hF;

    typedef enum logic [1:0] {
        VRD_DROP    = 2'd0,
        VRD_ARP_REQ = 2'd1,
        VRD_ARP_RPL = 2'd2,
        VRD_UDP     = 2'd3
    } t_verdict;

    typedef struct packed {
        logic [31:0] self_ip;
        logic [31:0] host_ip;
        logic [15:0] listen_port;
        logic [10:0] max_payload;
    } t_cfg;

    // one queue entry: an optional payload byte followed by an optional verdict
    typedef struct packed {
        logic        has_pay;
        logic [7:0]  pay_byte;
        logic        has_vrd;
        t_verdict    verdict;
        logic [47:0] mac;
        logic [31:0] ip;
        logic [10:0] plen;
    } t_entry;

endpackage

`default_nettype wire

// ===== src/aurf_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aurf_regs (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [3:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic      [31:0]    prdata,
    output logic                pready,
    output aurf_pkg::t_cfg      o_cfg
);

    aurf_pkg::t_cfg r_cfg;
    logic           s_wr;

    assign pready = 1'b1;
    assign s_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.self_ip     <= aurf_pkg::SELF_IP_RST;
            r_cfg.host_ip     <= aurf_pkg::HOST_IP_RST;
            r_cfg.listen_port <= aurf_pkg::LISTEN_PORT_RST;
            r_cfg.max_payload <= aurf_pkg::MAX_PAYLOAD_RST;
        end else if (s_wr) begin
            unique case (paddr[3:2])
                aurf_pkg::REG_SELF_IP:     r_cfg.self_ip     <= pwdata;
                aurf_pkg::REG_HOST_IP:     r_cfg.host_ip     <= pwdata;
                aurf_pkg::REG_LISTEN_PORT: r_cfg.listen_port <= pwdata[15:0];
                aurf_pkg::REG_MAX_PAYLOAD: r_cfg.max_payload <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            aurf_pkg::REG_SELF_IP:     prdata = r_cfg.self_ip;
            aurf_pkg::REG_HOST_IP:     prdata = r_cfg.host_ip;
            aurf_pkg::REG_LISTEN_PORT: prdata = {16'd0, r_cfg.listen_port};
            aurf_pkg::REG_MAX_PAYLOAD: prdata = {21'd0, r_cfg.max_payload};
            default:                   prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/aurf_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aurf_parser #(
    parameter int MAX_FRAME_BYTES = aurf_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic           i_last_byte,
    input  wire aurf_pkg::t_cfg i_cfg,
    output logic                o_push,
    output aurf_pkg::t_entry    o_entry
);

    localparam int OW = $clog2(MAX_FRAME_BYTES + 1);

    logic [OW-1:0] r_off,  n_off;
    logic [15:0]   r_et,   n_et;
    logic [15:0]   r_op,   n_op;
    logic [47:0]   r_mac,  n_mac;
    logic [31:0]   r_sip,  n_sip;
    logic [31:0]   r_tip,  n_tip;
    logic [5:0]    r_ihl,  n_ihl;
    logic          r_ipm,  n_ipm;
    logic [15:0]   r_port, n_port;
    logic [15:0]   r_ulen, n_ulen;
    logic [10:0]   r_cnt,  n_cnt;

    logic          s_active;
    logic [7:0]    s_want;
    logic [OW:0]   s_rel;
    logic          s_in_udp;
    logic [15:0]   s_ulen_m8;
    logic [10:0]   s_lim;
    logic          s_udp_ok;
    logic          s_udp_ok_n;
    logic [OW-1:0] s_len;
    logic          s_is_arp;
    logic          s_is_ip;
    logic          s_pay;

    assign s_active  = r_off < OW'(MAX_FRAME_BYTES);
    assign s_is_arp  = (r_off >= OW'(14)) && (r_et == aurf_pkg::ETH_TYPE_ARP);
    assign s_is_ip   = (r_off >= OW'(14)) && (r_et == aurf_pkg::ETH_TYPE_IPV4);
    // offset relative to the start of the UDP header; sign bit set when before it
    assign s_rel     = {1'b0, r_off} - (OW + 1)'(7'd14 + {1'b0, r_ihl});
    assign s_in_udp  = (r_ihl >= 6'd20) && !s_rel[OW];
    assign s_udp_ok  = r_ipm && (r_port == i_cfg.listen_port) && (r_ulen >= 16'd8);
    assign s_ulen_m8 = r_ulen - 16'd8;
    assign s_lim     = (s_ulen_m8 > {5'd0, i_cfg.max_payload}) ? i_cfg.max_payload
                                                                : s_ulen_m8[10:0];

    // own address byte compared at offsets 30..33, most significant first
    always_comb begin
        case (r_off[1:0])
            2'd2:    s_want = i_cfg.self_ip[31:24];
            2'd3:    s_want = i_cfg.self_ip[23:16];
            2'd0:    s_want = i_cfg.self_ip[15:8];
            default: s_want = i_cfg.self_ip[7:0];
        endcase
    end

    always_comb begin
        n_off   = r_off;
        n_et    = r_et;
        n_op    = r_op;
        n_mac   = r_mac;
        n_sip   = r_sip;
        n_tip   = r_tip;
        n_ihl   = r_ihl;
        n_ipm   = r_ipm;
        n_port  = r_port;
        n_ulen  = r_ulen;
        n_cnt   = r_cnt;
        s_pay   = 1'b0;
        o_push  = 1'b0;
        o_entry = '0;
        s_len   = r_off;
        s_udp_ok_n = 1'b0;

        if (i_accept) begin
            if (s_active) begin
                if (r_off == OW'(12)) begin
                    n_et = {i_data_byte, 8'h00};
                end else if (r_off == OW'(13)) begin
                    n_et = r_et | {8'h00, i_data_byte};
                end else if (s_is_arp) begin
                    if (r_off == OW'(20) || r_off == OW'(21)) begin
                        n_op = {r_op[7:0], i_data_byte};
                    end else if (r_off >= OW'(22) && r_off <= OW'(27)) begin
                        n_mac = {r_mac[39:0], i_data_byte};
                    end else if (r_off >= OW'(28) && r_off <= OW'(31)) begin
                        n_sip = {r_sip[23:0], i_data_byte};
                    end else if (r_off >= OW'(38) && r_off <= OW'(41)) begin
                        n_tip = {r_tip[23:0], i_data_byte};
                    end
                end else if (s_is_ip) begin
                    if (r_off == OW'(14)) begin
                        n_ihl = {i_data_byte[3:0] & aurf_pkg::IHL_MASK, 2'b00};
                    end else if (r_off == OW'(23)) begin
                        n_ipm = (i_data_byte == aurf_pkg::IP_PROTO_UDP);
                    end else if (r_off >= OW'(30) && r_off <= OW'(33)) begin
                        if (i_data_byte != s_want) begin
                            n_ipm = 1'b0;
                        end
                    end
                    if (s_in_udp) begin
                        if (s_rel == (OW + 1)'(2) || s_rel == (OW + 1)'(3)) begin
                            n_port = {r_port[7:0], i_data_byte};
                        end else if (s_rel == (OW + 1)'(4) || s_rel == (OW + 1)'(5)) begin
                            n_ulen = {r_ulen[7:0], i_data_byte};
                        end else if (s_rel >= (OW + 1)'(8) && s_udp_ok && r_cnt < s_lim) begin
                            s_pay = 1'b1;
                            n_cnt = r_cnt + 11'd1;
                        end
                    end
                end
                n_off = r_off + OW'(1);
            end

            o_entry.has_pay  = s_pay;
            o_entry.pay_byte = i_data_byte;
            o_push           = s_pay | i_last_byte;

            if (i_last_byte) begin
                // verdict sees the state including this byte
                s_len      = n_off;
                s_udp_ok_n = n_ipm && (n_port == i_cfg.listen_port) && (n_ulen >= 16'd8);
                o_entry.has_vrd = 1'b1;
                o_entry.verdict = aurf_pkg::VRD_DROP;
                if (n_et == aurf_pkg::ETH_TYPE_ARP && s_len >= OW'(42)) begin
                    if (n_op == aurf_pkg::ARP_OP_REQ && n_tip == i_cfg.self_ip) begin
                        o_entry.verdict = aurf_pkg::VRD_ARP_REQ;
                    end else if (n_op == aurf_pkg::ARP_OP_RPL && n_sip == i_cfg.host_ip) begin
                        o_entry.verdict = aurf_pkg::VRD_ARP_RPL;
                    end
                    if (o_entry.verdict != aurf_pkg::VRD_DROP) begin
                        o_entry.mac = n_mac;
                        o_entry.ip  = n_sip;
                    end
                end else if (n_et == aurf_pkg::ETH_TYPE_IPV4 && n_ihl >= 6'd20 &&
                             {1'b0, s_len} >= (OW + 1)'(7'd22 + {1'b0, n_ihl}) &&
                             s_udp_ok_n) begin
                    o_entry.verdict = aurf_pkg::VRD_UDP;
                    o_entry.plen    = n_cnt;
                end
                // drop all per-frame state
                n_off  = '0;
                n_et   = '0;
                n_op   = '0;
                n_mac  = '0;
                n_sip  = '0;
                n_tip  = '0;
                n_ihl  = '0;
                n_ipm  = 1'b0;
                n_port = '0;
                n_ulen = '0;
                n_cnt  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off  <= '0;
            r_et   <= '0;
            r_op   <= '0;
            r_mac  <= '0;
            r_sip  <= '0;
            r_tip  <= '0;
            r_ihl  <= '0;
            r_ipm  <= 1'b0;
            r_port <= '0;
            r_ulen <= '0;
            r_cnt  <= '0;
        end else begin
            r_off  <= n_off;
            r_et   <= n_et;
            r_op   <= n_op;
            r_mac  <= n_mac;
            r_sip  <= n_sip;
            r_tip  <= n_tip;
            r_ihl  <= n_ihl;
            r_ipm  <= n_ipm;
            r_port <= n_port;
            r_ulen <= n_ulen;
            r_cnt  <= n_cnt;
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last_byte) |=> (r_off == '0 && r_cnt == '0))
        else $error("frame state not cleared after last byte");

    a_pay_needs_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_entry.has_pay) |-> (r_ipm && r_cnt < i_cfg.max_payload))
        else $error("payload byte passed without a matching datagram");

endmodule

`default_nettype wire

// ===== src/aurf_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aurf_fifo #(
    parameter int DEPTH = aurf_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire aurf_pkg::t_entry i_wdata,
    input  wire logic             i_rd,
    output aurf_pkg::t_entry      o_rdata,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    aurf_pkg::t_entry r_mem [DEPTH];
    logic [AW-1:0]    r_wptr;
    logic [AW-1:0]    r_rptr;
    logic [CW-1:0]    r_count;
    logic             s_wr;
    logic             s_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign s_wr    = i_wr & ~o_full;
    assign s_rd    = i_rd & ~o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (s_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (s_wr) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (s_rd) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            if (s_wr && !s_rd) begin
                r_count <= r_count + CW'(1);
            end else if (s_rd && !s_wr) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_wr && !s_rd) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("queue count did not advance on write");

endmodule

`default_nettype wire

// ===== src/aurf_emit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aurf_emit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire aurf_pkg::t_entry i_head,
    input  wire logic             i_head_empty,
    output logic                  o_head_rd,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic                  o_kind,
    output logic [7:0]            o_payload_byte,
    output logic [1:0]            o_verdict,
    output logic [47:0]           o_sender_mac,
    output logic [31:0]           o_sender_ip,
    output logic [10:0]           o_payload_length,
    output logic                  o_end_of_frame
);

    aurf_pkg::t_entry r_ent;
    logic             r_valid;
    logic             r_pay_pend;
    logic             s_take;
    logic             s_done;
    logic             s_split;

    assign s_split   = r_valid & i_pop & r_pay_pend & r_ent.has_vrd;
    assign s_done    = r_valid & i_pop & ~(r_pay_pend & r_ent.has_vrd);
    assign s_take    = ~i_head_empty & (~r_valid | s_done);
    assign o_head_rd = s_take;

    assign o_empty          = ~r_valid;
    assign o_kind           = ~r_pay_pend;
    assign o_end_of_frame   = ~r_pay_pend;
    assign o_payload_byte   = r_pay_pend ? r_ent.pay_byte : 8'd0;
    assign o_verdict        = r_pay_pend ? 2'd0 : r_ent.verdict;
    assign o_sender_mac     = r_pay_pend ? 48'd0 : r_ent.mac;
    assign o_sender_ip      = r_pay_pend ? 32'd0 : r_ent.ip;
    assign o_payload_length = r_pay_pend ? 11'd0 : r_ent.plen;

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_ent <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_pay_pend <= 1'b0;
        end else if (s_take) begin
            r_valid    <= 1'b1;
            r_pay_pend <= i_head.has_pay;
        end else if (s_done) begin
            r_valid    <= 1'b0;
            r_pay_pend <= 1'b0;
        end else if (s_split) begin
            // payload byte delivered, hold the entry for its verdict
            r_pay_pend <= 1'b0;
        end
    end

    a_split_to_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_split |=> (r_valid && !r_pay_pend && $stable(r_ent)))
        else $error("verdict lost after payload byte");

endmodule

`default_nettype wire

// ===== src/arp_udp_receive_filter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Payload
// frame in  input      i_push / o_full         i_data_byte, i_last_byte
// result    output     o_empty / i_pop         o_kind, o_payload_byte, o_verdict,
//                                              o_sender_mac, o_sender_ip,
//                                              o_payload_length, o_end_of_frame
// config    input      psel/penable/pwrite     paddr, pwdata, prdata, pready
//
// One frame byte is taken every cycle while o_full is low; the parser classifies it
// in that cycle and writes at most one entry into a FIFO_DEPTH-deep queue.
// A result is written into the queue and then loaded into the output register, which
// takes it only once the previous result has been popped. A last byte that also
// carries payload yields two results: the payload byte, then the verdict.
// o_full rises only when the queue is full because results are not being popped.
// Reset is synchronous, active low, and clears frame state, queue, output and config.
module arp_udp_receive_filter_unit #(
    parameter int MAX_FRAME_BYTES = aurf_pkg::MAX_FRAME_BYTES_DEF,
    parameter int FIFO_DEPTH      = aurf_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    output logic                o_full,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic           i_last_byte,
    output logic                o_empty,
    input  wire logic           i_pop,
    output logic                o_kind,
    output logic [7:0]          o_payload_byte,
    output logic [1:0]          o_verdict,
    output logic [47:0]         o_sender_mac,
    output logic [31:0]         o_sender_ip,
    output logic [10:0]         o_payload_length,
    output logic                o_end_of_frame,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [3:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic      [31:0]    prdata,
    output logic                pready
);

    aurf_pkg::t_cfg   s_cfg;
    aurf_pkg::t_entry s_wentry;
    aurf_pkg::t_entry s_head;
    logic             s_accept;
    logic             s_qpush;
    logic             s_qempty;
    logic             s_qrd;

    assign s_accept = i_push & ~o_full;

    aurf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (s_cfg)
    );

    aurf_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (s_accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_cfg       (s_cfg),
        .o_push      (s_qpush),
        .o_entry     (s_wentry)
    );

    aurf_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (s_qpush),
        .i_wdata (s_wentry),
        .i_rd    (s_qrd),
        .o_rdata (s_head),
        .o_full  (o_full),
        .o_empty (s_qempty)
    );

    aurf_emit u_emit (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (s_head),
        .i_head_empty     (s_qempty),
        .o_head_rd        (s_qrd),
        .i_pop            (i_pop),
        .o_empty          (o_empty),
        .o_kind           (o_kind),
        .o_payload_byte   (o_payload_byte),
        .o_verdict        (o_verdict),
        .o_sender_mac     (o_sender_mac),
        .o_sender_ip      (o_sender_ip),
        .o_payload_length (o_payload_length),
        .o_end_of_frame   (o_end_of_frame)
    );

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic                kind;
        logic [7:0]          data;
        aurf_pkg::t_verdict  verdict;
        logic [47:0]         mac;
        logic [31:0]         ip;
        logic [10:0]         plen;
        logic                eof;
    } t_rx_result;

    // Frame parser mirror: tracks per-frame fields and queues the results each byte causes.
    class t_scoreboard;
        logic [31:0] self_ip;
        logic [31:0] host_ip;
        logic [15:0] listen_port;
        logic [10:0] max_payload;

        int unsigned offset;
        logic [15:0] ethertype;
        logic [15:0] opcode;
        logic [47:0] snd_mac;
        logic [31:0] snd_ip;
        logic [31:0] tgt_ip;
        int unsigned hdr_bytes;
        logic        ip_ok;
        logic [15:0] dport;
        logic [15:0] ulen;
        int unsigned pay_cnt;

        t_rx_result  expected_q[$];
        int          errors;

        function new();
            self_ip     = aurf_pkg::SELF_IP_RST;
            host_ip     = aurf_pkg::HOST_IP_RST;
            listen_port = aurf_pkg::LISTEN_PORT_RST;
            max_payload = aurf_pkg::MAX_PAYLOAD_RST;
            errors      = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            offset    = 0;
            ethertype = '0;
            opcode    = '0;
            snd_mac   = '0;
            snd_ip    = '0;
            tgt_ip    = '0;
            hdr_bytes = 0;
            ip_ok     = 1'b0;
            dport     = '0;
            ulen      = '0;
            pay_cnt   = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                aurf_pkg::REG_SELF_IP:     self_ip     = val;
                aurf_pkg::REG_HOST_IP:     host_ip     = val;
                aurf_pkg::REG_LISTEN_PORT: listen_port = val[15:0];
                aurf_pkg::REG_MAX_PAYLOAD: max_payload = val[10:0];
                default: ;
            endcase
        endfunction

        function bit udp_pass();
            return ip_ok && dport == listen_port && ulen >= 16'd8;
        endfunction

        function void push_result(logic kind, logic [7:0] data, aurf_pkg::t_verdict v,
                                  logic [47:0] mac, logic [31:0] ip, logic [10:0] plen);
            t_rx_result r;
            r.kind    = kind;
            r.data    = data;
            r.verdict = v;
            r.mac     = mac;
            r.ip      = ip;
            r.plen    = plen;
            r.eof     = kind;
            expected_q.push_back(r);
        endfunction

        function void take_byte(logic [7:0] b, logic last);
            int unsigned        o;
            int unsigned        u;
            int unsigned        lim;
            aurf_pkg::t_verdict v;
            logic [47:0]        mac;
            logic [31:0]        sip;
            logic [10:0]        plen;
            if (offset < aurf_pkg::MAX_FRAME_BYTES_DEF) begin
                o = offset;
                if (o == 12) begin
                    ethertype = {b, 8'h00};
                end else if (o == 13) begin
                    ethertype[7:0] = b;
                end else if (o >= 14 && ethertype == aurf_pkg::ETH_TYPE_ARP) begin
                    if (o == 20 || o == 21) opcode = {opcode[7:0], b};
                    else if (o >= 22 && o <= 27) snd_mac = {snd_mac[39:0], b};
                    else if (o >= 28 && o <= 31) snd_ip = {snd_ip[23:0], b};
                    else if (o >= 38 && o <= 41) tgt_ip = {tgt_ip[23:0], b};
                end else if (o >= 14 && ethertype == aurf_pkg::ETH_TYPE_IPV4) begin
                    if (o == 14) begin
                        hdr_bytes = 4 * (b[3:0] & aurf_pkg::IHL_MASK);
                    end else if (o == 23) begin
                        ip_ok = (b == aurf_pkg::IP_PROTO_UDP);
                    end else if (o >= 30 && o <= 33) begin
                        if (b != self_ip[8*(33-o) +: 8]) ip_ok = 1'b0;
                    end
                    if (hdr_bytes >= 20) begin
                        u = 14 + hdr_bytes;
                        if (o == u + 2 || o == u + 3) begin
                            dport = {dport[7:0], b};
                        end else if (o == u + 4 || o == u + 5) begin
                            ulen = {ulen[7:0], b};
                        end else if (o >= u + 8 && udp_pass()) begin
                            lim = ulen - 8;
                            if (lim > max_payload) lim = max_payload;
                            if (pay_cnt < lim) begin
                                push_result(1'b0, b, aurf_pkg::VRD_DROP, '0, '0, '0);
                                pay_cnt++;
                            end
                        end
                    end
                end
                offset++;
            end

            if (last) begin
                v    = aurf_pkg::VRD_DROP;
                mac  = '0;
                sip  = '0;
                plen = '0;
                if (ethertype == aurf_pkg::ETH_TYPE_ARP && offset >= 42) begin
                    if (opcode == aurf_pkg::ARP_OP_REQ && tgt_ip == self_ip)
                        v = aurf_pkg::VRD_ARP_REQ;
                    else if (opcode == aurf_pkg::ARP_OP_RPL && snd_ip == host_ip)
                        v = aurf_pkg::VRD_ARP_RPL;
                    if (v != aurf_pkg::VRD_DROP) begin
                        mac = snd_mac;
                        sip = snd_ip;
                    end
                end else if (ethertype == aurf_pkg::ETH_TYPE_IPV4 && hdr_bytes >= 20 &&
                             offset >= 14 + hdr_bytes + 8 && udp_pass()) begin
                    v    = aurf_pkg::VRD_UDP;
                    plen = pay_cnt[10:0];
                end
                push_result(1'b1, 8'h00, v, mac, sip, plen);
                clear_frame();
            end
        endfunction

        function string show(t_rx_result r);
            return $sformatf("kind=%0d data=%02h verdict=%0d mac=%012h ip=%08h len=%0d eof=%0d",
                             r.kind, r.data, r.verdict, r.mac, r.ip, r.plen, r.eof);
        endfunction

        function void check_result(t_rx_result got);
            t_rx_result want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result: %s", show(got));
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: expected %s", show(want));
                    $display("          actual   %s", show(got));
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_push;
    logic        o_full;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        o_empty;
    logic        i_pop;
    logic        o_kind;
    logic [7:0]  o_payload_byte;
    logic [1:0]  o_verdict;
    logic [47:0] o_sender_mac;
    logic [31:0] o_sender_ip;
    logic [10:0] o_payload_length;
    logic        o_end_of_frame;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    t_scoreboard         sb;
    logic [7:0]          frame_q[$];
    int                  bytes_sent = 0;
    int                  send_calm = 0;
    int                  cycle_count = 0;

    arp_udp_receive_filter_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (i_push),
        .o_full           (o_full),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .o_empty          (o_empty),
        .i_pop            (i_pop),
        .o_kind           (o_kind),
        .o_payload_byte   (o_payload_byte),
        .o_verdict        (o_verdict),
        .o_sender_mac     (o_sender_mac),
        .o_sender_ip      (o_sender_ip),
        .o_payload_length (o_payload_length),
        .o_end_of_frame   (o_end_of_frame),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Random wait per transaction, with occasional stretches of back-to-back traffic.
    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(10, 60);
        return $urandom_range(0, 10);
    endfunction

    initial begin : result_sink
        int         gap;
        int         calm;
        t_rx_result got;
        calm  = 0;
        i_pop = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            gap = draw_gap(calm);
            if (gap > 0) begin
                i_pop <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_pop <= 1'b1;
            @(posedge i_clk);
            while (o_empty !== 1'b0) @(posedge i_clk);
            got.kind    = o_kind;
            got.data    = o_payload_byte;
            got.verdict = aurf_pkg::t_verdict'(o_verdict);
            got.mac     = o_sender_mac;
            got.ip      = o_sender_ip;
            got.plen    = o_payload_length;
            got.eof     = o_end_of_frame;
            sb.check_result(got);
        end
    end

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_config(logic [31:0] own, logic [31:0] host,
                                logic [15:0] port, logic [10:0] cap);
        apb_write(aurf_pkg::REG_SELF_IP, own);
        apb_write(aurf_pkg::REG_HOST_IP, host);
        apb_write(aurf_pkg::REG_LISTEN_PORT, {16'h0000, port});
        apb_write(aurf_pkg::REG_MAX_PAYLOAD, {21'h0, cap});
    endtask

    task automatic push_frame_byte(logic [7:0] d, logic last);
        int gap;
        @(negedge i_clk);
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_push      <= 1'b1;
        i_data_byte <= d;
        i_last_byte <= last;
        @(posedge i_clk);
        while (o_full !== 1'b0) @(posedge i_clk);
        sb.take_byte(d, last);
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < frame_q.size(); i++)
            push_frame_byte(frame_q[i], i == frame_q.size() - 1);
        bytes_sent += frame_q.size();
    endtask

    // Hold off until every result is back, then let the parser drain before touching registers.
    task automatic wait_idle();
        @(negedge i_clk);
        i_push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic push_val(logic [63:0] v, int n);
        int i;
        for (i = n - 1; i >= 0; i--) frame_q.push_back(v[8*i +: 8]);
    endtask

    task automatic push_random(int n);
        int i;
        for (i = 0; i < n; i++) frame_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic build_udp(int ihl, logic [7:0] proto, logic [31:0] dst,
                             logic [15:0] port, int ulen, int npay);
        frame_q.delete();
        push_random(12);
        push_val(aurf_pkg::ETH_TYPE_IPV4, 2);
        push_val({4'($urandom_range(0, 15)), 4'(ihl)}, 1);
        push_random(8);
        push_val(proto, 1);
        push_random(6);
        push_val(dst, 4);
        if (ihl > 5) push_random(ihl * 4 - 20);
        push_random(2);
        push_val(port, 2);
        push_val(16'(ulen), 2);
        push_random(2);
        push_random(npay);
    endtask

    task automatic build_arp(logic [15:0] op, logic [47:0] smac, logic [31:0] sip,
                             logic [31:0] tip, int pad);
        frame_q.delete();
        push_random(12);
        push_val(aurf_pkg::ETH_TYPE_ARP, 2);
        push_random(6);
        push_val(op, 2);
        push_val(smac, 6);
        push_val(sip, 4);
        push_random(6);
        push_val(tip, 4);
        push_random(pad);
    endtask

    task automatic cut_frame(int keep);
        while (frame_q.size() > keep) frame_q.delete(frame_q.size() - 1);
    endtask

    task automatic run_directed();
        logic [31:0] g;
        logic [31:0] h;
        logic [15:0] p;
        int          i;
        g = sb.self_ip;
        h = sb.host_ip;
        p = sb.listen_port;

        build_arp(aurf_pkg::ARP_OP_REQ, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, g, 0);
        send_frame();
        build_arp(aurf_pkg::ARP_OP_RPL, 48'h0, h, $urandom, 18);
        send_frame();
        build_arp(16'd3, 48'h1234_5678_9ABC, h, g, 0);
        send_frame();
        build_arp(aurf_pkg::ARP_OP_REQ, 48'hA5A5_5A5A_0F0F, $urandom, g, 0);
        cut_frame(41);
        send_frame();

        // last byte is also a payload byte: two results in one step
        build_udp(5, aurf_pkg::IP_PROTO_UDP, g, p, 13, 5);
        send_frame();
        build_udp(5, aurf_pkg::IP_PROTO_UDP, g, p, 8, 0);
        send_frame();
        build_udp(5, aurf_pkg::IP_PROTO_UDP, g, p, 7, 3);
        send_frame();
        build_udp(4, aurf_pkg::IP_PROTO_UDP, g, p, 12, 4);
        send_frame();
        build_udp(5, aurf_pkg::IP_PROTO_UDP, g, p, 12, 4);
        cut_frame(40);
        send_frame();
        build_udp(5, aurf_pkg::IP_PROTO_UDP, g, p, 18, 3);
        send_frame();
        build_udp(5, aurf_pkg::IP_PROTO_UDP, g, p, 12, 9);
        send_frame();
        build_udp(5, aurf_pkg::IP_PROTO_UDP, g, p, 12, 4);
        frame_q[12] = 8'h86;
        frame_q[13] = 8'hDD;
        send_frame();

        // degenerate frames: a single byte, all ones
        frame_q.delete();
        frame_q.push_back(8'hFF);
        send_frame();
        frame_q.delete();
        for (i = 0; i < 20; i++) frame_q.push_back(8'hFF);
        send_frame();
    endtask

    task automatic random_frame();
        int          sel;
        int          fault;
        int          ihl;
        int          npay;
        int          ulen;
        int          k;
        logic [7:0]  proto;
        logic [31:0] dst;
        logic [15:0] port;
        logic [15:0] op;
        logic [47:0] mac;
        logic [31:0] sip;
        logic [31:0] tip;
        sel   = $urandom_range(0, 99);
        fault = -1;
        ihl   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
        npay  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 120) : $urandom_range(0, 24);
        ulen  = ($urandom_range(0, 3) == 0) ? 8 + $urandom_range(0, npay + 6) : npay + 8;
        proto = aurf_pkg::IP_PROTO_UDP;
        dst   = sb.self_ip;
        port  = sb.listen_port;

        if (sel < 45) begin
            build_udp(ihl, proto, dst, port, ulen, npay);
        end else if (sel < 65) begin
            k   = $urandom_range(0, 7);
            op  = (k == 0) ? 16'($urandom)
                           : ((k < 4) ? aurf_pkg::ARP_OP_REQ : aurf_pkg::ARP_OP_RPL);
            mac = {16'($urandom), 32'($urandom)};
            tip = (op == aurf_pkg::ARP_OP_REQ && $urandom_range(0, 3) != 0) ? sb.self_ip
                                                                          : $urandom;
            sip = (op == aurf_pkg::ARP_OP_RPL && $urandom_range(0, 3) != 0) ? sb.host_ip
                                                                          : $urandom;
            build_arp(op, mac, sip, tip, $urandom_range(0, 18));
        end else if (sel < 90) begin
            fault = $urandom_range(0, 5);
            case (fault)
                0: proto = 8'($urandom_range(0, 255));
                1: dst = dst ^ (32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3)));
                2: port = port ^ 16'($urandom_range(1, 65535));
                3: ulen = $urandom_range(0, 7);
                4: ihl = $urandom_range(0, 4);
                default: ;
            endcase
            build_udp(ihl, proto, dst, port, ulen, npay);
        end else begin
            frame_q.delete();
            push_random($urandom_range(1, 70));
            if (frame_q.size() > 13 && $urandom_range(0, 1) == 1) begin
                frame_q[12] = 8'h08;
                frame_q[13] = ($urandom_range(0, 1) == 1) ? 8'h06 : 8'h00;
            end
        end

        // chop the frame short now and then
        if (fault == 5 || $urandom_range(0, 19) == 0)
            cut_frame($urandom_range(1, frame_q.size()));
    endtask

    task automatic run_random(int budget);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            random_frame();
            send_frame();
        end
    endtask

    initial begin
        sb          = new();
        i_rst_n     = 1'b0;
        i_push      = 1'b0;
        i_data_byte = 8'h00;
        i_last_byte = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = 4'h0;
        pwdata      = 32'h0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        wait_idle();
        write_config($urandom, $urandom, 16'($urandom), 11'($urandom_range(0, 2047)));
        run_random(90);

        wait_idle();
        write_config(32'h0000_0000, 32'hFFFF_FFFF, 16'h0000, 11'd0);
        run_random(90);

        wait_idle();
        write_config(32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF, 11'd2047);
        run_random(90);

        wait_idle();
        write_config($urandom, $urandom, 16'($urandom), 11'($urandom_range(1, 6)));
        run_random(90);

        @(negedge i_clk);
        i_push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
